FILE: rtl/lppr_pkg.sv
// Shared types, widths and codes for the pixel-pair line rasterizer.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package lppr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int COLOR_W     = 16;
	localparam int OUT_BITS    = COORD_BITS + 1;
	localparam int SLOPE_BITS  = FRAC_BITS + 2;
	localparam int ACC_BITS    = COORD_BITS + FRAC_BITS + 1;
	localparam int NUM_W       = COORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_W   = $clog2(NUM_W);

	localparam int BLEND_NUM   = 10;
	localparam int BLEND_DEN   = 11;
	localparam int BLEND_W     = 20;
	localparam int BLEND_SHIFT = 26;
	localparam int BLEND_MW    = 23;
	localparam logic [BLEND_MW-1:0] BLEND_MULT =
		BLEND_MW'(((64'd1 << BLEND_SHIFT) + BLEND_DEN - 1) / BLEND_DEN);

	localparam int IN_PACK_W   = 4 * COORD_BITS + COLOR_W;
	localparam int IN_DATA_W   = ((IN_PACK_W + 7) / 8) * 8;
	localparam int OUT_PACK_W  = 4 * OUT_BITS + 2 * COLOR_W;
	localparam int OUT_DATA_W  = ((OUT_PACK_W + 7) / 8) * 8;

	localparam int PADDR_W     = 3;
	localparam logic REG_BACKGROUND = 1'b0;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0]   pcoord_t;
	typedef logic [COLOR_W-1:0]           color_t;

	typedef struct packed {
		coord_t u_start;
		coord_t v_start;
		coord_t u_end;
		coord_t v_end;
		color_t line_color;
	} in_item_t;

	typedef struct packed {
		pcoord_t main_px;
		pcoord_t main_py;
		pcoord_t side_px;
		pcoord_t side_py;
		color_t  main_shade;
		color_t  side_shade;
		logic    final_column;
		logic    no_line;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic orient;
		logic order;
		logic div_step;
		logic load;
		logic step;
		logic idle_step;
	} dp_cmd_t;

	typedef struct packed {
		logic line_active;
	} dp_sts_t;

endpackage

FILE: rtl/lppr_ctrl.sv
// Controller of the pixel-pair line rasterizer: sequences line setup,
// counts the slope divider iterations and owns the output valid flag.
// Depends on lppr_pkg.
module lppr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  lppr_pkg::dp_sts_t   sts,
	output lppr_pkg::dp_cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ORIENT = 5'b00010,
		ST_ORDER  = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_LOAD   = 5'b10000
	} state_t;

	state_t                           state_q, state_d;
	logic [lppr_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             out_valid_q;
	logic                             out_free;
	logic                             accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cmd.capture   = accept && (in_mode == lppr_pkg::MODE_START);
		cmd.step      = accept && (in_mode == lppr_pkg::MODE_STEP) && sts.line_active;
		cmd.idle_step = accept && (in_mode == lppr_pkg::MODE_STEP) && !sts.line_active;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_ORIENT;
			end
			ST_ORIENT: begin
				cmd.orient = 1'b1;
				state_d    = ST_ORDER;
			end
			ST_ORDER: begin
				cmd.order = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = out_free;
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.order) begin
				cnt_q <= lppr_pkg::DIV_CNT_W'(lppr_pkg::NUM_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.load || cmd.step || cmd.idle_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/lppr_dp.sv
// Datapath of the pixel-pair line rasterizer: endpoint ordering, bit-serial
// slope divider, neighbor color blend, DDA accumulator and result register.
// Depends on lppr_pkg; driven by lppr_ctrl.
module lppr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lppr_pkg::dp_cmd_t    cmd,
	output lppr_pkg::dp_sts_t    sts,
	input  lppr_pkg::in_item_t   in_item,
	input  lppr_pkg::color_t     bg_color,
	output lppr_pkg::out_item_t  out_item
);

	localparam int CB = lppr_pkg::COORD_BITS;
	localparam int FB = lppr_pkg::FRAC_BITS;
	localparam int AB = lppr_pkg::ACC_BITS;
	localparam int SB = lppr_pkg::SLOPE_BITS;
	localparam int NW = lppr_pkg::NUM_W;
	localparam int OB = lppr_pkg::OUT_BITS;
	localparam int BW = lppr_pkg::BLEND_W;
	localparam int PW = BW + lppr_pkg::BLEND_MW;

	// Captured endpoints.
	lppr_pkg::coord_t u0_q, v0_q, u1_q, v1_q;
	lppr_pkg::color_t color_q;

	// Axis selection.
	logic                steep_n_q;
	lppr_pkg::coord_t    a0_q, b0_q, a1_q, b1_q;

	// Ordered span and divider.
	lppr_pkg::coord_t    amin_q, amax_q, bmin_q;
	logic [CB-1:0]       da_q;
	logic                dneg_q;
	logic [BW-1:0]       blend_sum_q;
	lppr_pkg::color_t    blend_q;
	logic [CB-1:0]       rem_q;
	logic [NW-1:0]       num_q;

	// Line state.
	logic                line_active_q;
	logic                steep_q;
	lppr_pkg::coord_t    pos_q, end_q;
	logic signed [AB-1:0] acc_q;
	logic signed [SB-1:0] slope_q;
	lppr_pkg::color_t    held_color_q, held_side_q;

	lppr_pkg::out_item_t out_q;

	logic signed [CB:0]  du, dv, da_w, db_w;
	logic [CB-1:0]       adu, adv, mag_c, da_c;
	logic                steep_c, swap_c;
	lppr_pkg::coord_t    amin_c, amax_c, bmin_c, bmax_c;
	logic [NW-1:0]       num_c;
	logic [BW-1:0]       blend_c;
	logic [PW-1:0]       blend_prod;
	logic [CB:0]         trial;
	logic                ge;
	logic [SB-2:0]       qmag;
	logic signed [SB-1:0] slope_c;
	logic signed [AB-1:0] acc_init, e_acc;
	logic                e_steep, e_last;
	lppr_pkg::coord_t    e_pos, e_end;
	lppr_pkg::color_t    e_color, e_side;
	logic signed [OB-1:0] m_px, m1_px, maj;

	always_comb begin
		du      = {u1_q[CB-1], u1_q} - {u0_q[CB-1], u0_q};
		dv      = {v1_q[CB-1], v1_q} - {v0_q[CB-1], v0_q};
		adu     = du[CB] ? CB'(-du) : du[CB-1:0];
		adv     = dv[CB] ? CB'(-dv) : dv[CB-1:0];
		steep_c = adu > adv;

		swap_c  = a0_q > a1_q;
		amin_c  = swap_c ? a1_q : a0_q;
		amax_c  = swap_c ? a0_q : a1_q;
		bmin_c  = swap_c ? b1_q : b0_q;
		bmax_c  = swap_c ? b0_q : b1_q;
		da_w    = {amax_c[CB-1], amax_c} - {amin_c[CB-1], amin_c};
		db_w    = {bmax_c[CB-1], bmax_c} - {bmin_c[CB-1], bmin_c};
		da_c    = da_w[CB-1:0];
		mag_c   = db_w[CB] ? CB'(-db_w) : db_w[CB-1:0];
		num_c   = {mag_c, {FB{1'b0}}} + NW'(da_c >> 1);
		blend_c = BW'(color_q) * BW'(lppr_pkg::BLEND_NUM) + BW'(bg_color);

		trial   = {rem_q, num_q[NW-1]};
		ge      = trial >= {1'b0, da_q};
	end

	assign blend_prod = PW'(blend_sum_q) * PW'(lppr_pkg::BLEND_MULT);

	// Slope and accumulator values of a fresh line.
	always_comb begin
		qmag     = num_q[SB-2:0];
		if (da_q == '0) begin
			slope_c = SB'(1) <<< FB;
		end else if (dneg_q) begin
			slope_c = -$signed({1'b0, qmag});
		end else begin
			slope_c = $signed({1'b0, qmag});
		end
		acc_init = {bmin_q[CB-1], bmin_q, {FB{1'b0}}};
	end

	// Column to emit: either the first of a new line or the next step.
	always_comb begin
		if (cmd.load) begin
			e_steep = steep_n_q;
			e_pos   = amin_q;
			e_end   = amax_q;
			e_acc   = acc_init;
			e_color = color_q;
			e_side  = steep_n_q ? blend_q : color_q;
		end else begin
			e_steep = steep_q;
			e_pos   = pos_q + 1'b1;
			e_end   = end_q;
			e_acc   = acc_q + {{(AB-SB){slope_q[SB-1]}}, slope_q};
			e_color = held_color_q;
			e_side  = held_side_q;
		end
		m_px   = e_acc[AB-1:FB] + OB'(e_acc[AB-1] && (|e_acc[FB-1:0]));
		m1_px  = m_px + 1'b1;
		maj    = {e_pos[CB-1], e_pos};
		e_last = e_pos >= e_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
		end else if (cmd.load || cmd.step) begin
			line_active_q <= !e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			u0_q    <= in_item.u_start;
			v0_q    <= in_item.v_start;
			u1_q    <= in_item.u_end;
			v1_q    <= in_item.v_end;
			color_q <= in_item.line_color;
		end
		if (cmd.orient) begin
			steep_n_q <= steep_c;
			a0_q      <= steep_c ? u0_q : v0_q;
			b0_q      <= steep_c ? v0_q : u0_q;
			a1_q      <= steep_c ? u1_q : v1_q;
			b1_q      <= steep_c ? v1_q : u1_q;
		end
		if (cmd.order) begin
			amin_q      <= amin_c;
			amax_q      <= amax_c;
			bmin_q      <= bmin_c;
			da_q        <= da_c;
			dneg_q      <= db_w[CB];
			num_q       <= num_c;
			rem_q       <= '0;
			blend_sum_q <= blend_c;
		end
		if (cmd.div_step) begin
			rem_q   <= ge ? CB'(trial - {1'b0, da_q}) : trial[CB-1:0];
			num_q   <= {num_q[NW-2:0], ge};
			blend_q <= blend_prod[lppr_pkg::BLEND_SHIFT +: lppr_pkg::COLOR_W];
		end
		if (cmd.load) begin
			steep_q      <= steep_n_q;
			end_q        <= amax_q;
			slope_q      <= slope_c;
			held_color_q <= e_color;
			held_side_q  <= e_side;
		end
		if (cmd.load || cmd.step) begin
			pos_q              <= e_pos;
			acc_q              <= e_acc;
			out_q.main_px      <= e_steep ? m_px : maj;
			out_q.main_py      <= e_steep ? maj : m_px;
			out_q.side_px      <= e_steep ? m1_px : maj;
			out_q.side_py      <= e_steep ? maj : m1_px;
			out_q.main_shade   <= e_color;
			out_q.side_shade   <= e_side;
			out_q.final_column <= e_last;
			out_q.no_line      <= 1'b0;
		end else if (cmd.idle_step) begin
			out_q.main_px      <= '0;
			out_q.main_py      <= '0;
			out_q.side_px      <= '0;
			out_q.side_py      <= '0;
			out_q.main_shade   <= '0;
			out_q.side_shade   <= '0;
			out_q.final_column <= 1'b0;
			out_q.no_line      <= 1'b1;
		end
	end

	assign sts.line_active = line_active_q;
	assign out_item        = out_q;

endmodule

FILE: rtl/line_pixel_pair_rasterizer_core.sv
// Top level of the pixel-pair line rasterizer: stream ports, APB register
// and the controller/datapath pair. Depends on lppr_pkg, lppr_ctrl, lppr_dp.
//
// A start transfer (tuser 0) takes endpoints and a color and returns the
// first column via the orient, order, divide and load states, the 28-bit
// restoring divider forming the slope. A step transfer (tuser 1) returns the
// next column (a no-line result if no line is active) from the output register
// in the cycle after it is taken, so steps stream at one item per cycle while
// the output is drained. The background color is sampled when a line starts.
module line_pixel_pair_rasterizer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// u_start, v_start, u_end, v_end, line_color
	input  logic [lppr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// mode
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// main_px, main_py, side_px, side_py, main_shade, side_shade
	output logic [lppr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// no_line
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lppr_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	lppr_pkg::dp_cmd_t   cmd;
	lppr_pkg::dp_sts_t   sts;
	lppr_pkg::in_item_t  in_item;
	lppr_pkg::out_item_t out_item;
	lppr_pkg::color_t    bg_color_q;
	logic                reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[lppr_pkg::PADDR_W-1] == lppr_pkg::REG_BACKGROUND;
	assign prdata  = reg_sel ? 32'(bg_color_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_color_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			bg_color_q <= pwdata[lppr_pkg::COLOR_W-1:0];
		end
	end

	assign {in_item.line_color, in_item.v_end, in_item.u_end,
		in_item.v_start, in_item.u_start} = s_axis_tdata[lppr_pkg::IN_PACK_W-1:0];

	assign m_axis_tdata = lppr_pkg::OUT_DATA_W'({out_item.side_shade, out_item.main_shade,
		out_item.side_py, out_item.side_px, out_item.main_py, out_item.main_px});
	assign m_axis_tuser = out_item.no_line;
	assign m_axis_tlast = out_item.final_column;

	lppr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_mode   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	lppr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_item  (in_item),
		.bg_color (bg_color_q),
		.out_item (out_item)
	);

endmodule

FILE: rtl/lppr_checker.sv
// Port checker for the pixel-pair line rasterizer, bound to the top level.
// Depends on lppr_pkg.
module lppr_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [lppr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [lppr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tuser,
	input  logic                            m_axis_tlast
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// A result without a line carries no pixels and no end mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
		else $error("no-line result carries data");

	// A step transfer yields its result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == lppr_pkg::MODE_STEP)
		|=> m_axis_tvalid)
		else $error("step result missing");

	// An input transfer is only taken when the output register can be freed.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
		else $error("input taken while output blocked");

endmodule

bind line_pixel_pair_rasterizer_core lppr_checker u_lppr_checker (.*);
